// ===== sv/srb_pkg.sv =====
// ----------------------------------------------------------------------------
// srb_pkg: shared types and constants for the slot state ring buffer
// Holds slot count, field widths, operation and status codes, the command
// that travels from the front end through the queue to the back end, and
// the helpers that derive the in-use ring size and advance a pointer.
// ----------------------------------------------------------------------------
`default_nettype none

package srb_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int PTR_W     = 4;   // slot index width
  localparam int CNT_W     = 5;   // fill count and ring size width
  localparam int DATA_W    = 32;
  localparam int MODE_W    = 3;
  localparam int STATE_W   = 2;
  localparam int STATUS_W  = 2;

  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;

  localparam logic [CNT_W-1:0] RING_MAX   = CNT_W'(NUM_SLOTS);
  localparam logic [CNT_W-1:0] RING_MIN   = CNT_W'(1);
  localparam logic [CNT_W-1:0] FILL_SAT   = {CNT_W{1'b1}};

  // Input mode codes
  localparam logic [MODE_W-1:0] MODE_ACQUIRE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FILLED    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PLAY      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PLAYED    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SET_STATE = 3'd4;

  // Slot states
  localparam logic [STATE_W-1:0] SLOT_EMPTY    = 2'd0;
  localparam logic [STATE_W-1:0] SLOT_ACQUIRED = 2'd1;
  localparam logic [STATE_W-1:0] SLOT_READY    = 2'd2;
  localparam logic [STATE_W-1:0] SLOT_PLAYING  = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BUSY      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

  typedef enum logic [2:0] {
    OP_ACQUIRE,
    OP_FILLED,
    OP_PLAY,
    OP_PLAYED,
    OP_SET_STATE,
    OP_BAD_INDEX,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [DATA_W-1:0]  seq;
    logic [DATA_W-1:0]  size;
    logic [PTR_W-1:0]   idx;
    logic [STATE_W-1:0] new_state;
  } cmd_t;

  function automatic logic [CNT_W-1:0] eff_size(input logic [CNT_W-1:0] rs);
    logic [CNT_W-1:0] r;
    r = rs;
    if (rs == '0) r = RING_MIN;
    else if (rs > RING_MAX) r = RING_MAX;
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p,
                                                   input logic [CNT_W-1:0] eff);
    logic [CNT_W-1:0] n;
    n = {{(CNT_W-PTR_W){1'b0}}, p} + CNT_W'(1);
    return (n >= eff) ? '0 : n[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/srb_front.sv =====
// ----------------------------------------------------------------------------
// srb_front: input decode
// Takes input items, classifies the mode into a command, range-checks the
// set_state index against the ring size, and pushes the command to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module srb_front import srb_pkg::*; (
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [MODE_W-1:0]   mode_i,
  input  wire logic [DATA_W-1:0]   seq_i,
  input  wire logic [DATA_W-1:0]   data_size_i,
  input  wire logic [PTR_W-1:0]    slot_index_i,
  input  wire logic [STATE_W-1:0]  new_state_i,
  input  wire logic [CNT_W-1:0]    eff_size_i,
  input  wire logic                q_full_i,
  output logic                     push_o,
  output cmd_t                     cmd_o
);

  op_e op;

  always_comb begin
    case (mode_i)
      MODE_ACQUIRE:   op = OP_ACQUIRE;
      MODE_FILLED:    op = OP_FILLED;
      MODE_PLAY:      op = OP_PLAY;
      MODE_PLAYED:    op = OP_PLAYED;
      MODE_SET_STATE: begin
        op = ({1'b0, slot_index_i} < eff_size_i) ? OP_SET_STATE : OP_BAD_INDEX;
      end
      default:        op = OP_NOP;
    endcase
  end

  assign cmd_o.op        = op;
  assign cmd_o.seq       = seq_i;
  assign cmd_o.size      = data_size_i;
  assign cmd_o.idx       = slot_index_i;
  assign cmd_o.new_state = new_state_i;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

`default_nettype wire

// ===== sv/srb_queue.sv =====
// ----------------------------------------------------------------------------
// srb_queue: command queue
// Short FIFO between decode and execution so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module srb_queue import srb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      push_cmd_i,
  input  wire logic pop_i,
  output cmd_t      pop_cmd_o,
  output logic      empty_o,
  output logic      full_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign empty_o   = (count_q == '0);
  assign full_o    = (count_q == QCNT_W'(QDEPTH));
  assign pop_cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) count_d = count_q + QCNT_W'(1);
    else if (!push_i && pop_i) count_d = count_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

`default_nettype wire

// ===== sv/srb_back.sv =====
// ----------------------------------------------------------------------------
// srb_back: command execution
// Owns the ring state (pointers, fill count, slot states, seq and size) and
// runs one command per cycle into a registered result stage, barring stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module srb_back import srb_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [CNT_W-1:0]     eff_size_i,
  input  cmd_t                      cmd_i,
  input  wire logic                 q_empty_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [STATUS_W-1:0]       status_o,
  output logic [PTR_W-1:0]          slot_o,
  output logic [DATA_W-1:0]         seq_out_o,
  output logic [DATA_W-1:0]         size_out_o
);

  logic [STATE_W-1:0] slot_state_q [NUM_SLOTS];
  logic [DATA_W-1:0]  slot_seq_q   [NUM_SLOTS];
  logic [DATA_W-1:0]  slot_size_q  [NUM_SLOTS];

  logic [PTR_W-1:0]   head_q, head_d;
  logic [PTR_W-1:0]   tail_q, tail_d;
  logic [CNT_W-1:0]   fill_q, fill_d;

  logic               out_valid_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [PTR_W-1:0]   slot_q, slot_d;
  logic [DATA_W-1:0]  seq_out_q;
  logic [DATA_W-1:0]  size_out_q;

  logic [PTR_W-1:0]   addr;
  logic [STATE_W-1:0] cur_state;
  logic               st_we;
  logic [STATE_W-1:0] st_wd;
  logic               data_we;
  logic               play_ok;

  // Advance when the result stage is free or being drained this cycle
  assign pop_o = !q_empty_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    case (cmd_i.op)
      OP_ACQUIRE, OP_FILLED: addr = tail_q;
      OP_PLAY, OP_PLAYED:    addr = head_q;
      default:               addr = cmd_i.idx;
    endcase
  end

  assign cur_state = slot_state_q[addr];

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    st_we    = 1'b0;
    st_wd    = SLOT_EMPTY;
    data_we  = 1'b0;
    play_ok  = 1'b0;
    status_d = ST_OK;
    slot_d   = '0;
    case (cmd_i.op)
      OP_ACQUIRE: begin
        slot_d = tail_q;
        if (fill_q >= eff_size_i || cur_state != SLOT_EMPTY) begin
          status_d = ST_BUSY;
        end else begin
          st_we = 1'b1;
          st_wd = SLOT_ACQUIRED;
        end
      end
      OP_FILLED: begin
        slot_d  = tail_q;
        st_we   = 1'b1;
        st_wd   = SLOT_READY;
        data_we = 1'b1;
        tail_d  = ptr_advance(tail_q, eff_size_i);
        if (fill_q != FILL_SAT) fill_d = fill_q + CNT_W'(1);
      end
      OP_PLAY: begin
        slot_d = head_q;
        if (cur_state == SLOT_READY) begin
          st_we   = 1'b1;
          st_wd   = SLOT_PLAYING;
          play_ok = 1'b1;
        end else begin
          status_d = ST_NOT_READY;
        end
      end
      OP_PLAYED: begin
        slot_d = head_q;
        st_we  = 1'b1;
        st_wd  = SLOT_EMPTY;
        head_d = ptr_advance(head_q, eff_size_i);
        if (fill_q != '0) fill_d = fill_q - CNT_W'(1);
      end
      OP_SET_STATE: begin
        slot_d = cmd_i.idx;
        st_we  = 1'b1;
        st_wd  = cmd_i.new_state;
      end
      OP_BAD_INDEX: begin
        slot_d   = cmd_i.idx;
        status_d = ST_BAD_INDEX;
      end
      default: begin
        slot_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) slot_state_q[i] <= SLOT_EMPTY;
    end else begin
      if (pop_o) begin
        head_q <= head_d;
        tail_q <= tail_d;
        fill_q <= fill_d;
        if (st_we) slot_state_q[addr] <= st_wd;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Slot payload and result stage: no reset needed
  always_ff @(posedge clk_i) begin
    if (pop_o && data_we) begin
      slot_seq_q[addr]  <= cmd_i.seq;
      slot_size_q[addr] <= cmd_i.size;
    end
    if (pop_o) begin
      status_q   <= status_d;
      slot_q     <= slot_d;
      seq_out_q  <= play_ok ? slot_seq_q[addr]  : '0;
      size_out_q <= play_ok ? slot_size_q[addr] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign seq_out_o   = seq_out_q;
  assign size_out_o  = size_out_q;

endmodule

`default_nettype wire

// ===== sv/slot_state_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// slot_state_ring_buffer: descriptor ring with per-slot state
// Front end decodes operations into a two-entry queue; back end executes.
// ----------------------------------------------------------------------------
// Every accepted operation gives exactly one result. An operation is
// accepted into the two-entry command queue and its result is loaded into
// the output register once the command leaves the queue and that register
// is free; the back end retires one command
// per cycle, so with the output not stalled the block sustains one
// operation per cycle, limited by the single slot-state update the back end
// makes each cycle. Input stall rises only when the queue is full. The ring
// size register is written through the cfg channel (always ready) and must
// only change while no operation is in flight.
`default_nettype none

module slot_state_ring_buffer import srb_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CNT_W-1:0]    cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [MODE_W-1:0]   mode_i,
  input  wire logic [DATA_W-1:0]   seq_i,
  input  wire logic [DATA_W-1:0]   data_size_i,
  input  wire logic [PTR_W-1:0]    slot_index_i,
  input  wire logic [STATE_W-1:0]  new_state_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [PTR_W-1:0]         slot_o,
  output logic [DATA_W-1:0]        seq_out_o,
  output logic [DATA_W-1:0]        size_out_o
);

  logic [CNT_W-1:0] ring_size_q;
  logic [CNT_W-1:0] eff;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  cmd_t             push_cmd;
  cmd_t             pop_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_size_q <= RING_MAX;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ring_size_q <= cfg_data_i;
    end
  end

  assign eff = eff_size(ring_size_q);

  srb_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .seq_i        (seq_i),
    .data_size_i  (data_size_i),
    .slot_index_i (slot_index_i),
    .new_state_i  (new_state_i),
    .eff_size_i   (eff),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  srb_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  srb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eff_size_i  (eff),
    .cmd_i       (pop_cmd),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .slot_o      (slot_o),
    .seq_out_o   (seq_out_o),
    .size_out_o  (size_out_o)
  );

endmodule

`default_nettype wire

// ===== sv/srb_checker.sv =====
// ----------------------------------------------------------------------------
// srb_checker: port-level checks for the slot state ring buffer
// Watches the result channel and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module srb_checker import srb_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [STATUS_W-1:0] status_o,
  input wire logic [PTR_W-1:0]    slot_o,
  input wire logic [DATA_W-1:0]   seq_out_o,
  input wire logic [DATA_W-1:0]   size_out_o
);

  // A held result keeps its valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A held result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o) && $stable(slot_o)
                                   && $stable(seq_out_o) && $stable(size_out_o))
    else $error("result payload changed while stalled");

  // Only a successful play returns seq and size
  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> seq_out_o == '0 && size_out_o == '0)
    else $error("nonzero payload on a failed operation");

  // No result is shown once reset has been seen at an edge
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind slot_state_ring_buffer srb_checker u_srb_checker (.*);

`default_nettype wire
